// File: hw/rtl/tsat_pkg.sv
// Package for the task scheduler accounting table.
// Types, codes and widths shared by the interfaces and modules. No dependencies.
package tsat_pkg;

  localparam int TaskSlots = 256;
  localparam int SlotW = $clog2(TaskSlots);

  typedef enum logic [2:0] {
    KIND_WAKEUP = 3'd0,
    KIND_SW_OUT = 3'd1,
    KIND_SW_IN  = 3'd2,
    KIND_MIGRATE = 3'd3,
    KIND_EXIT   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_CREATED = 3'd1,
    ST_STALE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_DELETED = 3'd4,
    ST_ABSENT  = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] now_ns;
    logic [31:0] task_id;
    logic [31:0] group_id;
    logic [63:0] start_time_ns;
    logic [63:0] cgroup_ref;
    logic [9:0]  cpu;
    logic        still_runnable;
  } event_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] group_out;
    logic [31:0] wakeups;
    logic [31:0] switches;
    logic [31:0] migrations;
    logic [63:0] runtime_total;
    logic [63:0] wait_total;
    logic [9:0]  cpu_last;
    logic [63:0] cgroup_out;
  } result_t;

  // One stored entry, without key and valid bit.
  typedef struct packed {
    logic [31:0] group;
    logic [63:0] start;
    logic [63:0] cgroup;
    logic [31:0] wakeups;
    logic [31:0] switches;
    logic [31:0] migrations;
    logic [9:0]  cpu;
    logic [63:0] runtime;
    logic [63:0] wait_ns;
    logic [63:0] run_since;
    logic [63:0] queued_since;
  } entry_t;

  // Outcome of a key scan, handed from the scanner to the sequencer.
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             has_free;
    logic [SlotW-1:0] free_slot;
  } scan_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// File: hw/rtl/tsat_event_if.sv
// Valid/ready channel carrying one scheduler event.
// Depends on tsat_pkg.
interface tsat_event_if;
  logic             valid;
  logic             ready;
  tsat_pkg::event_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/tsat_result_if.sv
// Valid/ready channel carrying one result request.
// Depends on tsat_pkg.
interface tsat_result_if;
  logic              valid;
  logic              ready;
  tsat_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/tsat_key_scan.sv
// Key store and sequential scanner: one slot per cycle, finds the task match
// and the lowest free slot. Holds the valid bits. Depends on tsat_pkg.
module tsat_key_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                key,
  output logic                       done,
  output tsat_pkg::scan_t            result,
  input  logic                       wr_en,
  input  logic                       wr_valid,
  input  logic [tsat_pkg::SlotW-1:0] wr_slot,
  input  logic [31:0]                wr_key
);

  logic [31:0]                key_mem [tsat_pkg::TaskSlots];
  logic [tsat_pkg::TaskSlots-1:0] valid_bits;
  logic [tsat_pkg::SlotW:0]   addr;
  logic [tsat_pkg::SlotW-1:0] rd_slot;
  logic [31:0]                rd_key;
  logic                       rd_valid;
  logic                       rd_live;
  logic                       busy;
  logic [31:0]                key_q;
  tsat_pkg::scan_t            acc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_slot] <= wr_key;
    end
    rd_key <= key_mem[addr[tsat_pkg::SlotW-1:0]];
    rd_valid <= valid_bits[addr[tsat_pkg::SlotW-1:0]];
    rd_slot <= addr[tsat_pkg::SlotW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      busy <= 1'b0;
      rd_live <= 1'b0;
      done <= 1'b0;
      addr <= '0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        valid_bits[wr_slot] <= wr_valid;
      end
      rd_live <= busy && !addr[tsat_pkg::SlotW];
      if (start) begin
        busy <= 1'b1;
        addr <= '0;
        key_q <= key;
        acc <= '0;
      end else if (busy) begin
        if (!addr[tsat_pkg::SlotW]) begin
          addr <= addr + 1'b1;
        end
        if (rd_live) begin
          if (rd_valid && rd_key == key_q && !acc.hit) begin
            acc.hit <= 1'b1;
            acc.hit_slot <= rd_slot;
          end
          if (!rd_valid && !acc.has_free) begin
            acc.has_free <= 1'b1;
            acc.free_slot <= rd_slot;
          end
        end else if (addr[tsat_pkg::SlotW]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

endmodule

// File: hw/rtl/tsat_entry_update.sv
// Combinational entry update for one event: zeroing of new or stale entries,
// counters and time accumulation. Depends on tsat_pkg.
module tsat_entry_update (
  input  tsat_pkg::event_t ev,
  input  tsat_pkg::entry_t cur,
  input  logic             fresh,
  output tsat_pkg::entry_t nxt
);

  tsat_pkg::entry_t base;

  always_comb begin
    base = fresh ? '0 : cur;
    nxt = base;
    nxt.group = ev.group_id;
    nxt.start = ev.start_time_ns;
    case (ev.kind)
      tsat_pkg::KIND_WAKEUP: begin
        nxt.wakeups = tsat_pkg::sat_inc(base.wakeups);
        nxt.queued_since = ev.now_ns;
        nxt.cgroup = ev.cgroup_ref;
      end
      tsat_pkg::KIND_SW_OUT: begin
        nxt.switches = tsat_pkg::sat_inc(base.switches);
        nxt.cpu = ev.cpu;
        nxt.cgroup = ev.cgroup_ref;
        if (base.run_since != '0 && ev.now_ns > base.run_since) begin
          nxt.runtime = base.runtime + (ev.now_ns - base.run_since);
        end
        nxt.run_since = '0;
        if (ev.still_runnable) begin
          nxt.queued_since = ev.now_ns;
        end
      end
      tsat_pkg::KIND_SW_IN: begin
        nxt.switches = tsat_pkg::sat_inc(base.switches);
        nxt.cpu = ev.cpu;
        nxt.cgroup = ev.cgroup_ref;
        if (base.queued_since != '0 && ev.now_ns > base.queued_since) begin
          nxt.wait_ns = base.wait_ns + (ev.now_ns - base.queued_since);
        end
        nxt.queued_since = '0;
        nxt.run_since = ev.now_ns;
      end
      default: begin
        nxt.migrations = tsat_pkg::sat_inc(base.migrations);
        nxt.cpu = ev.cpu;
      end
    endcase
  end

endmodule

// File: hw/rtl/task_sched_accounting_table.sv
// Top level of the task scheduler accounting table: sequencer, entry memory,
// key scanner and entry update. Depends on tsat_pkg and both channel interfaces.
//
//  channel  dir  payload    request moves
//  evt      in   event_t    one scheduler event
//  res      out  result_t   one result per event
//
// An event is accepted only in idle; it then runs a full key scan at one slot
// per cycle, then an entry read, update and write back (skipped when the
// result is absent or table full).
// Reset clears the valid bits at once; no clearing pass.
// A finished result waits in the output register; the next event is taken
// while it waits, and the block stalls only when it must hand over another.
module task_sched_accounting_table (
  input logic          clk,
  input logic          rst,
  tsat_event_if.sink   evt,
  tsat_result_if.source res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_READ  = 5'b00100,
    S_WRITE = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t                     state;
  tsat_pkg::event_t           ev;
  tsat_pkg::scan_t            scan;
  logic                       scan_done;
  logic                       scan_start;
  logic [tsat_pkg::SlotW-1:0] slot;
  logic                       fresh;
  logic [2:0]                 status;
  tsat_pkg::entry_t           entry_mem [tsat_pkg::TaskSlots];
  tsat_pkg::entry_t           rd_entry;
  tsat_pkg::entry_t           upd_entry;
  logic                       mem_we;
  logic                       key_we;
  logic                       key_valid;
  tsat_pkg::result_t          pend;
  logic                       out_valid;
  tsat_pkg::result_t          out_data;

  // result with only a status and all other fields zero
  function automatic tsat_pkg::result_t bare_result(input logic [2:0] st);
    tsat_pkg::result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  assign evt.ready = (state == S_IDLE);
  assign scan_start = evt.valid && evt.ready;
  assign res.valid = out_valid;
  assign res.data = out_data;

  tsat_key_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .key      (evt.data.task_id),
    .done     (scan_done),
    .result   (scan),
    .wr_en    (key_we),
    .wr_valid (key_valid),
    .wr_slot  (slot),
    .wr_key   (ev.task_id)
  );

  tsat_entry_update u_upd (
    .ev    (ev),
    .cur   (rd_entry),
    .fresh (fresh),
    .nxt   (upd_entry)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[slot] <= upd_entry;
    end
    rd_entry <= entry_mem[slot];
  end

  always_comb begin
    mem_we = (state == S_WRITE) && (ev.kind != tsat_pkg::KIND_EXIT);
    key_we = (state == S_WRITE);
    key_valid = (ev.kind != tsat_pkg::KIND_EXIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_HOLD && (!out_valid || res.ready)) begin
        out_valid <= 1'b1;
        out_data <= pend;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (scan_start) begin
            ev <= evt.data;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (ev.kind > tsat_pkg::KIND_EXIT) begin
              pend <= bare_result(tsat_pkg::ST_ABSENT);
              state <= S_HOLD;
            end else if (ev.kind == tsat_pkg::KIND_EXIT) begin
              if (scan.hit) begin
                slot <= scan.hit_slot;
                status <= tsat_pkg::ST_DELETED;
                state <= S_READ;
              end else begin
                pend <= bare_result(tsat_pkg::ST_ABSENT);
                state <= S_HOLD;
              end
            end else if (scan.hit) begin
              slot <= scan.hit_slot;
              status <= tsat_pkg::ST_UPDATED;
              state <= S_READ;
            end else if (scan.has_free) begin
              slot <= scan.free_slot;
              status <= tsat_pkg::ST_CREATED;
              state <= S_READ;
            end else begin
              pend <= bare_result(tsat_pkg::ST_FULL);
              state <= S_HOLD;
            end
          end
        end
        S_READ: begin
          // memory output is registered here and is valid in S_WRITE
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (status == tsat_pkg::ST_DELETED) begin
            pend <= {status, rd_entry.group, rd_entry.wakeups, rd_entry.switches,
                     rd_entry.migrations, rd_entry.runtime, rd_entry.wait_ns,
                     rd_entry.cpu, rd_entry.cgroup};
          end else begin
            pend <= {(fresh && status == tsat_pkg::ST_UPDATED) ?
                       3'(tsat_pkg::ST_STALE) : status,
                     upd_entry.group, upd_entry.wakeups, upd_entry.switches,
                     upd_entry.migrations, upd_entry.runtime, upd_entry.wait_ns,
                     upd_entry.cpu, upd_entry.cgroup};
          end
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign fresh = (status == tsat_pkg::ST_CREATED) ||
                 (rd_entry.start != ev.start_time_ns);

endmodule

// File: sim/task_sched_accounting_table_tb.sv
// Testbench for task_sched_accounting_table: directed event table, then random
// event streams and a table overfill, checked against an in-bench accounting model.
// Depends on tsat_pkg, tsat_event_if, tsat_result_if and the RTL top level.
`timescale 1ns / 1ps

module task_sched_accounting_table_tb;

  localparam int NumItems = 1950;
  localparam int PoolSize = 48;

  typedef struct {
    logic [31:0] group;
    logic [63:0] start;
    logic [63:0] cgroup;
    logic [31:0] wakeups;
    logic [31:0] switches;
    logic [31:0] migrations;
    logic [9:0]  cpu;
    logic [63:0] runtime;
    logic [63:0] wait_ns;
    logic [63:0] run_since;
    logic [63:0] queued_since;
  } acct_rec_t;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] now_ns;
    logic [31:0] task_id;
    logic [63:0] start;
    logic [63:0] cgroup;
    logic [9:0]  cpu;
    logic        runnable;
    logic        has_status;
    logic [2:0]  status;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsat_event_if  evt_ch ();
  tsat_result_if res_ch ();

  task_sched_accounting_table dut (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .res(res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model of the table
  bit          live [tsat_pkg::TaskSlots];
  logic [31:0] key [tsat_pkg::TaskSlots];
  acct_rec_t   recs [tsat_pkg::TaskSlots];

  tsat_pkg::result_t expected_q[$];
  int      errors;
  int      results_seen;
  int      events_sent;
  int      drops_seen;
  int      deletes_seen;
  int      stale_seen;
  bit      quiet;

  logic [31:0] pool_id [PoolSize];
  logic [63:0] pool_start [PoolSize];
  logic [63:0] now_ctr;

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic tsat_pkg::result_t account_event(input tsat_pkg::event_t ev);
    tsat_pkg::result_t r;
    int s;
    int f;
    acct_rec_t e;
    r = '0;
    s = -1;
    f = -1;
    if (ev.kind > tsat_pkg::KIND_EXIT) begin
      r.status = tsat_pkg::ST_ABSENT;
      return r;
    end
    for (int i = 0; i < tsat_pkg::TaskSlots; i++)
      if (s < 0 && live[i] && key[i] == ev.task_id) s = i;
    if (ev.kind == tsat_pkg::KIND_EXIT) begin
      if (s < 0) begin
        r.status = tsat_pkg::ST_ABSENT;
        return r;
      end
      r.status = tsat_pkg::ST_DELETED;
      live[s] = 1'b0;
    end else begin
      if (s < 0) begin
        for (int i = 0; i < tsat_pkg::TaskSlots; i++)
          if (f < 0 && !live[i]) f = i;
        if (f < 0) begin
          r.status = tsat_pkg::ST_FULL;
          return r;
        end
        s = f;
        live[s] = 1'b1;
        key[s] = ev.task_id;
        recs[s] = '{default: '0};
        r.status = tsat_pkg::ST_CREATED;
      end else if (recs[s].start != ev.start_time_ns) begin
        recs[s] = '{default: '0};
        r.status = tsat_pkg::ST_STALE;
      end else begin
        r.status = tsat_pkg::ST_UPDATED;
      end
      e = recs[s];
      e.group = ev.group_id;
      e.start = ev.start_time_ns;
      case (ev.kind)
        tsat_pkg::KIND_WAKEUP: begin
          e.wakeups = sat_up(e.wakeups);
          e.queued_since = ev.now_ns;
          e.cgroup = ev.cgroup_ref;
        end
        tsat_pkg::KIND_SW_OUT: begin
          e.switches = sat_up(e.switches);
          e.cpu = ev.cpu;
          e.cgroup = ev.cgroup_ref;
          if (e.run_since != 0 && ev.now_ns > e.run_since)
            e.runtime = e.runtime + (ev.now_ns - e.run_since);
          e.run_since = '0;
          if (ev.still_runnable) e.queued_since = ev.now_ns;
        end
        tsat_pkg::KIND_SW_IN: begin
          e.switches = sat_up(e.switches);
          e.cpu = ev.cpu;
          e.cgroup = ev.cgroup_ref;
          if (e.queued_since != 0 && ev.now_ns > e.queued_since)
            e.wait_ns = e.wait_ns + (ev.now_ns - e.queued_since);
          e.queued_since = '0;
          e.run_since = ev.now_ns;
        end
        default: begin
          e.migrations = sat_up(e.migrations);
          e.cpu = ev.cpu;
        end
      endcase
      recs[s] = e;
    end
    r.group_out     = recs[s].group;
    r.wakeups       = recs[s].wakeups;
    r.switches      = recs[s].switches;
    r.migrations    = recs[s].migrations;
    r.runtime_total = recs[s].runtime;
    r.wait_total    = recs[s].wait_ns;
    r.cpu_last      = recs[s].cpu;
    r.cgroup_out    = recs[s].cgroup;
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 6);
  endfunction

  // drive one request; inputs change on the falling edge only, and valid
  // stays up with stable data until the request is taken
  task automatic send_event(input tsat_pkg::event_t ev);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      if (!evt_ch.valid && idle_now()) begin
        evt_ch.valid = 1'b0;
      end else begin
        evt_ch.valid = 1'b1;
        evt_ch.data = ev;
        @(posedge clk);
        if (evt_ch.ready) begin
          expected_q.push_back(account_event(ev));
          events_sent++;
          done = 1'b1;
        end
      end
    end
    @(negedge clk);
    evt_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string nm, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch result %0d %s: expected %h, got %h",
                 results_seen, nm, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    tsat_pkg::result_t exp_r;
    tsat_pkg::result_t act_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      act_r = res_ch.data;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result, status %0d", act_r.status);
      end else begin
        exp_r = expected_q.pop_front();
        check_field("status", 64'(exp_r.status), 64'(act_r.status));
        check_field("group_out", 64'(exp_r.group_out), 64'(act_r.group_out));
        check_field("wakeups", 64'(exp_r.wakeups), 64'(act_r.wakeups));
        check_field("switches", 64'(exp_r.switches), 64'(act_r.switches));
        check_field("migrations", 64'(exp_r.migrations), 64'(act_r.migrations));
        check_field("runtime_total", exp_r.runtime_total, act_r.runtime_total);
        check_field("wait_total", exp_r.wait_total, act_r.wait_total);
        check_field("cpu_last", 64'(exp_r.cpu_last), 64'(act_r.cpu_last));
        check_field("cgroup_out", exp_r.cgroup_out, act_r.cgroup_out);
        if (exp_r.status == tsat_pkg::ST_FULL) drops_seen++;
        if (exp_r.status == tsat_pkg::ST_DELETED) deletes_seen++;
        if (exp_r.status == tsat_pkg::ST_STALE) stale_seen++;
      end
      results_seen++;
    end
  end

  // receiver stalls
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = !idle_now();
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic tsat_pkg::event_t mk_event(input logic [2:0] kind,
                                                input logic [63:0] now,
                                                input logic [31:0] task_id,
                                                input logic [63:0] start,
                                                input logic [63:0] cgroup,
                                                input logic [9:0] cpu,
                                                input logic runnable);
    tsat_pkg::event_t ev;
    ev.kind = kind;
    ev.now_ns = now;
    ev.task_id = task_id;
    ev.group_id = {$urandom()};
    ev.start_time_ns = start;
    ev.cgroup_ref = cgroup;
    ev.cpu = cpu;
    ev.still_runnable = runnable;
    return ev;
  endfunction

  function automatic logic [63:0] next_stamp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 2) return {$urandom(), $urandom()};
    if (pick < 3) return '0;
    now_ctr = now_ctr + 64'($urandom_range(5000, 1));
    return now_ctr;
  endfunction

  task automatic random_event(input int p);
    int pick;
    int q;
    logic [63:0] stamp;
    logic [2:0] kind;
    pick = $urandom_range(99);
    stamp = next_stamp();
    if ($urandom_range(29) == 0) pool_start[p] = {$urandom(), $urandom()};
    if (pick < 30) begin
      // context switch: out for one task, in for a randomly picked task (possibly the same) at the same time
      q = $urandom_range(PoolSize - 1);
      send_event(mk_event(tsat_pkg::KIND_SW_OUT, stamp, pool_id[p], pool_start[p],
                          {$urandom(), $urandom()}, 10'($urandom()), 1'($urandom())));
      send_event(mk_event(tsat_pkg::KIND_SW_IN, stamp, pool_id[q], pool_start[q],
                          {$urandom(), $urandom()}, 10'($urandom()), 1'($urandom())));
    end else begin
      if (pick < 55) kind = tsat_pkg::KIND_WAKEUP;
      else if (pick < 70) kind = tsat_pkg::KIND_SW_OUT;
      else if (pick < 82) kind = tsat_pkg::KIND_SW_IN;
      else if (pick < 91) kind = tsat_pkg::KIND_MIGRATE;
      else if (pick < 98) kind = tsat_pkg::KIND_EXIT;
      else kind = 3'($urandom_range(7, 5));
      send_event(mk_event(kind, stamp, pool_id[p], pool_start[p],
                          {$urandom(), $urandom()}, 10'($urandom()), 1'($urandom())));
    end
  endtask

  step_row_t steps[$];

  initial begin
    tsat_pkg::event_t ev;
    evt_ch.valid = 1'b0;
    evt_ch.data = '0;
    errors = 0;
    results_seen = 0;
    events_sent = 0;
    drops_seen = 0;
    deletes_seen = 0;
    stale_seen = 0;
    quiet = 1'b0;
    now_ctr = 64'd1000;
    for (int i = 0; i < tsat_pkg::TaskSlots; i++) live[i] = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      pool_id[i] = (i < 8) ? 32'(i) : $urandom();
      pool_start[i] = {$urandom(), $urandom()};
    end

    // kind, now, task, start, cgroup, cpu, runnable, status check flag, expected status
    steps = '{
      '{tsat_pkg::KIND_EXIT, 64'd5, 32'd5, 64'd0, 64'd0, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_ABSENT},
      '{3'd7, 64'd5, 32'd5, 64'd0, 64'd0, 10'd0, 1'b0, 1'b1, tsat_pkg::ST_ABSENT},
      '{tsat_pkg::KIND_WAKEUP, 64'd100, 32'd0, 64'd0, 64'd9, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_CREATED},
      '{tsat_pkg::KIND_SW_IN, 64'd150, 32'd0, 64'd0, 64'd9, 10'd1023, 1'b0, 1'b1,
        tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_SW_OUT, 64'd400, 32'd0, 64'd0, 64'd9, 10'd3, 1'b1, 1'b1,
        tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_MIGRATE, 64'd410, 32'd0, 64'd0, 64'd1, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_UPDATED},
      // now earlier than the queue time: no wait added
      '{tsat_pkg::KIND_SW_IN, 64'd300, 32'd0, 64'd0, 64'd2, 10'd5, 1'b0, 1'b0,
        tsat_pkg::ST_UPDATED},
      // run start set, now earlier: no runtime added
      '{tsat_pkg::KIND_SW_OUT, 64'd200, 32'd0, 64'd0, 64'd2, 10'd5, 1'b0, 1'b0,
        tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_WAKEUP, 64'd500, 32'd0, 64'd77, 64'd3, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_STALE},
      // zero timestamp switch in: queue time set, now not later
      '{tsat_pkg::KIND_SW_IN, 64'd0, 32'd0, 64'd77, 64'd3, 10'd2, 1'b0, 1'b1,
        tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_SW_OUT, 64'd900, 32'd0, 64'd77, 64'd3, 10'd2, 1'b0, 1'b1,
        tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_SW_IN, '1, '1, '1, '1, '1, 1'b1, 1'b1, tsat_pkg::ST_CREATED},
      '{tsat_pkg::KIND_SW_OUT, '1, '1, '1, '1, '1, 1'b1, 1'b1, tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_WAKEUP, 64'd1, '1, '1, '1, '1, 1'b0, 1'b1, tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_SW_IN, '1, '1, '1, 64'd0, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_SW_OUT, 64'd3, '1, '1, 64'd0, 10'd0, 1'b1, 1'b1,
        tsat_pkg::ST_UPDATED},
      '{tsat_pkg::KIND_EXIT, 64'd0, '1, '1, 64'd0, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_DELETED},
      '{tsat_pkg::KIND_EXIT, 64'd0, 32'd0, 64'd0, 64'd0, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_DELETED},
      '{tsat_pkg::KIND_EXIT, 64'd0, 32'd0, 64'd0, 64'd0, 10'd0, 1'b0, 1'b1,
        tsat_pkg::ST_ABSENT},
      '{3'd5, '1, '1, '1, '1, '1, 1'b1, 1'b1, tsat_pkg::ST_ABSENT},
      '{3'd6, 64'd1, 32'd1, 64'd1, 64'd1, 10'd1, 1'b0, 1'b1, tsat_pkg::ST_ABSENT}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (steps[i]) begin
      ev = mk_event(steps[i].kind, steps[i].now_ns, steps[i].task_id, steps[i].start,
                    steps[i].cgroup, steps[i].cpu, steps[i].runnable);
      send_event(ev);
      if (steps[i].has_status && expected_q[$].status !== steps[i].status) begin
        errors++;
        $display("predicted status %0d for step %0d, table says %0d",
                 expected_q[$].status, i, steps[i].status);
      end
    end

    while (events_sent < 500) random_event($urandom_range(PoolSize - 1));

    // wait for the block to go empty, then overfill the table and delete those tasks again
    drain();
    for (int i = 0; i < tsat_pkg::TaskSlots + 6; i++)
      send_event(mk_event(tsat_pkg::KIND_WAKEUP, next_stamp(), 32'h8000_0000 + i,
                          64'd42, {$urandom(), $urandom()}, 10'($urandom()), 1'b0));
    for (int i = 0; i < tsat_pkg::TaskSlots + 6; i++)
      send_event(mk_event(tsat_pkg::KIND_EXIT, next_stamp(), 32'h8000_0000 + i,
                          64'd42, 64'd0, 10'd0, 1'b0));

    while (events_sent < NumItems) begin
      quiet = (events_sent >= 1300 && events_sent < 1550);
      random_event($urandom_range(PoolSize - 1));
    end
    quiet = 1'b0;

    @(negedge clk);
    evt_ch.valid = 1'b0;
    drain();
    repeat (300) @(posedge clk);

    $display("sent %0d events, checked %0d results", events_sent, results_seen);
    $display("table full drops %0d, deletes %0d, stale replacements %0d",
             drops_seen, deletes_seen, stale_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tsat_pkg.sv
hw/rtl/tsat_event_if.sv
hw/rtl/tsat_result_if.sv
hw/rtl/tsat_key_scan.sv
hw/rtl/tsat_entry_update.sv
hw/rtl/task_sched_accounting_table.sv
sim/task_sched_accounting_table_tb.sv
